>>> sv/ptbc_pkg.sv
// Shared types, constants and codes for the presence table with bulk clear.
package ptbc_pkg;

  localparam int unsigned ENTRY_COUNT = 65536;
  localparam int unsigned IDX_W       = $clog2(ENTRY_COUNT);
  localparam int unsigned CNT_W       = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned GEN_W       = 32;
  localparam int unsigned TAG_W       = GEN_W + 1;
  localparam int unsigned CODE_W      = 31;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned MODE_W      = 3;

  localparam logic [MODE_W-1:0] MODE_LOGIN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOGOUT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

  localparam logic signed [31:0] REPLY_ABSENT = -32'sd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   entry_id;
    logic [CODE_W-1:0] entry_code;
  } item_t;

  typedef struct packed {
    logic signed [31:0] reply;
    logic signed [63:0] running_total;
    logic               epoch_overflow;
  } result_t;

  typedef struct packed {
    logic             present;
    logic [GEN_W-1:0] tag;
  } tag_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    tag_entry_t       wr_data;
  } tag_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CODE_W-1:0] wr_data;
  } code_req_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

>>> sv/ptbc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ptbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/ptbc_engine.sv
// Sequencer, table update logic, counters and result register of the presence table.
module ptbc_engine
  import ptbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  output tag_req_t   tag_req,
  input  tag_entry_t tag_rd,
  output code_req_t  code_req,
  input  logic [CODE_W-1:0] code_rd
);

  state_t            state, state_next;
  item_t             item_q;
  logic [IDX_W-1:0]  sweep_addr, sweep_addr_next;
  logic [GEN_W-1:0]  generation, generation_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [63:0]       total, total_next;
  logic              overflow, overflow_next;
  logic              result_valid_next;
  result_t           result_next;

  logic              exec_fire;
  logic              in_range;
  logic              live;
  logic [IDX_W-1:0]  entry_addr;

  assign item_ready = (state == ST_IDLE);
  assign exec_fire  = (state == ST_EXEC) && (!result_valid || result_ready);
  assign in_range   = (32'(item_q.entry_id) < ENTRY_COUNT);
  assign entry_addr = IDX_W'(item_q.entry_id);
  assign live       = tag_rd.present && (tag_rd.tag == generation);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_addr   <= '0;
      generation   <= '0;
      count        <= '0;
      total        <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      sweep_addr   <= sweep_addr_next;
      generation   <= generation_next;
      count        <= count_next;
      total        <= total_next;
      overflow     <= overflow_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    result <= result_next;
  end

  always_comb begin
    state_next        = state;
    sweep_addr_next   = sweep_addr;
    generation_next   = generation;
    count_next        = count;
    total_next        = total;
    overflow_next     = overflow;
    result_valid_next = result_valid && !result_ready;
    result_next       = result;

    // While idle the read follows the offered item, so its data is ready in the next cycle.
    tag_req.rd_addr   = (state == ST_IDLE) ? IDX_W'(item.entry_id) : entry_addr;
    tag_req.wr_en     = 1'b0;
    tag_req.wr_addr   = entry_addr;
    tag_req.wr_data   = '{present: 1'b1, tag: generation};
    code_req.rd_addr  = tag_req.rd_addr;
    code_req.wr_en    = 1'b0;
    code_req.wr_addr  = entry_addr;
    code_req.wr_data  = item_q.entry_code;

    unique case (state)
      ST_SWEEP: begin
        tag_req.wr_en   = 1'b1;
        tag_req.wr_addr = sweep_addr;
        tag_req.wr_data = '0;
        if (sweep_addr == IDX_W'(ENTRY_COUNT - 1)) begin
          state_next = ST_IDLE;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_next        = ST_IDLE;
          result_valid_next = 1'b1;
          result_next.reply = '0;
          unique case (item_q.mode)
            MODE_LOGIN: begin
              if (in_range) begin
                if (!live && count < CNT_W'(ENTRY_COUNT)) begin
                  count_next = count + 1'b1;
                end
                tag_req.wr_en  = 1'b1;
                code_req.wr_en = 1'b1;
              end
            end
            MODE_LOGOUT: begin
              if (in_range) begin
                if (live && count != '0) begin
                  count_next = count - 1'b1;
                end
                tag_req.wr_en   = 1'b1;
                tag_req.wr_data = '{present: 1'b0, tag: tag_rd.tag};
              end
            end
            MODE_CLEAR: begin
              if (generation == '1) begin
                overflow_next = 1'b1;
              end
              generation_next = generation + 1'b1;
              count_next      = '0;
            end
            MODE_COUNT: begin
              result_next.reply = 32'(count);
              total_next        = total + 64'(count);
            end
            MODE_QUERY: begin
              if (in_range && live) begin
                result_next.reply = 32'(code_rd);
                total_next        = total + 64'(code_rd);
              end else begin
                result_next.reply = REPLY_ABSENT;
                total_next        = total - 64'd1;
              end
            end
            default: begin
            end
          endcase
          result_next.running_total  = total_next;
          result_next.epoch_overflow = overflow_next;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_EXEC))
    else $error("result appeared without a completed table update");

  a_sweep_writes_only_tags: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (tag_req.wr_en && !code_req.wr_en && !item_ready))
    else $error("clearing pass overlapped item processing");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRY_COUNT))
    else $error("present count exceeded the table size");

  a_clear_zeroes_count: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && item_q.mode == MODE_CLEAR) |=> (count == '0))
    else $error("bulk clear left a nonzero present count");

endmodule

>>> sv/presence_table_with_bulk_clear_core.sv
// Top level of the presence table with bulk clear: two table memories and the engine.
//
// Each item is handled in two steps: the first reads its table entry from the
// synchronous tag and code memories, the second updates counters, writes the
// entry back and loads the result register. The second step waits while a
// finished result is still held, and no new item is taken until it is done.
// A finished result waits in its own register while the next item is already
// taken. After reset the block runs a clearing pass over the tag memory, one
// entry per cycle, and takes no item until the pass is done. A bulk clear
// advances the generation; entries tagged with an older generation read as
// absent.
module presence_table_with_bulk_clear_core
  import ptbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  tag_req_t          tag_req;
  tag_entry_t        tag_rd;
  code_req_t         code_req;
  logic [CODE_W-1:0] code_rd;

  ptbc_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .tag_req      (tag_req),
    .tag_rd       (tag_rd),
    .code_req     (code_req),
    .code_rd      (code_rd)
  );

  ptbc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRY_COUNT)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_req.wr_en),
    .wr_addr (tag_req.wr_addr),
    .wr_data (tag_req.wr_data),
    .rd_addr (tag_req.rd_addr),
    .rd_data (tag_rd)
  );

  ptbc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (ENTRY_COUNT)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (code_req.wr_en),
    .wr_addr (code_req.wr_addr),
    .wr_data (code_req.wr_data),
    .rd_addr (code_req.rd_addr),
    .rd_data (code_rd)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the presence table with bulk clear: directed script, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptbc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_LAST  = 3'd7;

  // The clearing pass after reset accepts no item while it runs over the whole tag memory.
  localparam int unsigned IDLE_LIMIT    = 4 * ENTRY_COUNT;
  localparam int unsigned RANDOM_OPS    = 1924;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned MAX_REPORTED  = 10;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    entry_id;
    logic [CODE_W-1:0]  entry_code;
    logic               has_reply;
    logic signed [31:0] reply;
  } script_row_t;

  // Rows with has_reply set carry the reply that the operation must give.
  localparam script_row_t SCRIPT [26] = '{
    '{MODE_COUNT,          16'h0000, 31'h00000000, 1'b1, 32'sd0},
    '{MODE_QUERY,          16'h0000, 31'h00000000, 1'b1, REPLY_ABSENT},
    '{MODE_LOGIN,          16'h0000, 31'h7FFFFFFF, 1'b1, 32'sd0},
    '{MODE_LOGIN,          16'hFFFF, 31'h00000000, 1'b1, 32'sd0},
    '{MODE_QUERY,          16'h0000, 31'h00000000, 1'b1, 32'sh7FFFFFFF},
    '{MODE_QUERY,          16'hFFFF, 31'h7FFFFFFF, 1'b1, 32'sd0},
    '{MODE_COUNT,          16'h0000, 31'h00000000, 1'b1, 32'sd2},
    '{MODE_LOGIN,          16'h0000, 31'h2AAAAAAA, 1'b1, 32'sd0},
    '{MODE_COUNT,          16'h0000, 31'h00000000, 1'b1, 32'sd2},
    '{MODE_QUERY,          16'h0000, 31'h00000000, 1'b1, 32'sh2AAAAAAA},
    '{MODE_LOGOUT,         16'hFFFF, 31'h00000000, 1'b1, 32'sd0},
    '{MODE_LOGOUT,         16'hFFFF, 31'h00000000, 1'b1, 32'sd0},
    '{MODE_COUNT,          16'h0000, 31'h00000000, 1'b1, 32'sd1},
    '{MODE_QUERY,          16'hFFFF, 31'h00000000, 1'b1, REPLY_ABSENT},
    '{MODE_RSVD_FIRST,     16'h5555, 31'h55555555, 1'b1, 32'sd0},
    '{MODE_RSVD_FIRST + 3'd1, 16'hAAAA, 31'h2AAAAAAA, 1'b1, 32'sd0},
    '{MODE_RSVD_LAST,      16'hFFFF, 31'h7FFFFFFF, 1'b1, 32'sd0},
    '{MODE_LOGIN,          16'h1234, 31'h12345678, 1'b1, 32'sd0},
    '{MODE_COUNT,          16'h0000, 31'h00000000, 1'b1, 32'sd2},
    '{MODE_CLEAR,          16'hFFFF, 31'h7FFFFFFF, 1'b1, 32'sd0},
    '{MODE_COUNT,          16'h0000, 31'h00000000, 1'b1, 32'sd0},
    '{MODE_QUERY,          16'h0000, 31'h00000000, 1'b1, REPLY_ABSENT},
    '{MODE_QUERY,          16'h1234, 31'h00000000, 1'b1, REPLY_ABSENT},
    '{MODE_LOGIN,          16'h1234, 31'h00000001, 1'b1, 32'sd0},
    '{MODE_QUERY,          16'h1234, 31'h00000000, 1'b1, 32'sd1},
    '{MODE_LOGOUT,         16'hAAAA, 31'h00000000, 1'b1, 32'sd0}
  };

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   op_bus       = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t reply_bus;

  // Shadow copy of the table and its counters.
  bit              seen_present [ENTRY_COUNT];
  bit [GEN_W-1:0]  seen_tag     [ENTRY_COUNT];
  bit [CODE_W-1:0] stored_code  [ENTRY_COUNT];
  bit [GEN_W-1:0]  generation   = '0;
  bit [CNT_W-1:0]  live_count   = '0;
  bit [63:0]       reply_sum    = '0;
  bit              epoch_wrapped = 1'b0;

  result_t     pending_replies [$];
  result_t     oldest_reply;
  bit [ID_W-1:0] hot_ids [16];
  bit          no_idle_stretch = 1'b0;
  int unsigned mismatch_count  = 0;
  int unsigned idle_cycles     = 0;

  presence_table_with_bulk_clear_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (op_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (reply_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t apply_table_op(item_t op);
    result_t r;
    bit      live;
    r = '0;
    live = seen_present[op.entry_id] && (seen_tag[op.entry_id] == generation);
    case (op.mode)
      MODE_LOGIN: begin
        if (!live && live_count < ENTRY_COUNT) live_count++;
        seen_present[op.entry_id] = 1'b1;
        seen_tag[op.entry_id]     = generation;
        stored_code[op.entry_id]  = op.entry_code;
      end
      MODE_LOGOUT: begin
        if (live && live_count > 0) live_count--;
        seen_present[op.entry_id] = 1'b0;
      end
      MODE_CLEAR: begin
        if (generation == '1) epoch_wrapped = 1'b1;
        generation++;
        live_count = '0;
      end
      MODE_COUNT: begin
        r.reply   = 32'(live_count);
        reply_sum = reply_sum + 64'(live_count);
      end
      MODE_QUERY: begin
        if (live) begin
          r.reply   = 32'(stored_code[op.entry_id]);
          reply_sum = reply_sum + 64'(stored_code[op.entry_id]);
        end else begin
          r.reply   = REPLY_ABSENT;
          reply_sum = reply_sum - 64'd1;
        end
      end
      default: ;
    endcase
    r.running_total  = reply_sum;
    r.epoch_overflow = epoch_wrapped;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle_stretch ? 0 : $urandom_range(0, 4);
  endfunction

  // Mostly a small set of ids, so that logins are later found by queries.
  function automatic item_t random_op();
    item_t op;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op.mode = MODE_LOGIN;
    else if (pick < 45) op.mode = MODE_LOGOUT;
    else if (pick < 49) op.mode = MODE_CLEAR;
    else if (pick < 64) op.mode = MODE_COUNT;
    else if (pick < 94) op.mode = MODE_QUERY;
    else                op.mode = MODE_RSVD_FIRST + 3'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) op.entry_id = 16'($urandom);
    else                           op.entry_id = hot_ids[$urandom_range(0, 15)];
    op.entry_code = 31'($urandom);
    return op;
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the transfer.
  task automatic send_op(item_t op, logic has_reply, logic signed [31:0] fixed_reply);
    int unsigned gap;
    result_t     want;
    gap = draw_wait();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_bus     <= op;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    want = apply_table_op(op);
    if (has_reply) want.reply = fixed_reply;
    pending_replies.push_back(want);
  endtask

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endfunction

  initial begin : result_side
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("transfer with nothing pending", '0, reply_bus.running_total);
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (reply_bus.reply !== oldest_reply.reply)
          flag_mismatch("reply", 64'(oldest_reply.reply), 64'(reply_bus.reply));
        if (reply_bus.running_total !== oldest_reply.running_total)
          flag_mismatch("running_total", oldest_reply.running_total, reply_bus.running_total);
        if (reply_bus.epoch_overflow !== oldest_reply.epoch_overflow)
          flag_mismatch("epoch_overflow", 64'(oldest_reply.epoch_overflow),
                        64'(reply_bus.epoch_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    item_t op;
    int    k;
    hot_ids[0] = '0;
    hot_ids[1] = '1;
    for (k = 2; k < 16; k++) hot_ids[k] = 16'($urandom);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < $size(SCRIPT); k++) begin
      op.mode       = SCRIPT[k].mode;
      op.entry_id   = SCRIPT[k].entry_id;
      op.entry_code = SCRIPT[k].entry_code;
      send_op(op, SCRIPT[k].has_reply, SCRIPT[k].reply);
    end

    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % 100 == 0) no_idle_stretch = ($urandom_range(0, 3) == 0);
      send_op(random_op(), 1'b0, '0);
    end
    item_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ptbc_pkg.sv
sv/ptbc_ram.sv
sv/ptbc_engine.sv
sv/presence_table_with_bulk_clear_core.sv
dv/tb_top.sv
